>>> rtl/fud_pkg.sv
// Shared types, codes and helpers for the form-urlencoded decoder.
// No dependencies; every other file in rtl imports this package.
package fud_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } fud_kind_e;

  typedef enum logic [1:0] {
    PHASE_NONE  = 2'd0,
    PHASE_FIRST = 2'd1,
    PHASE_SECND = 2'd2
  } fud_phase_e;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    fud_kind_e  kind;
    logic [7:0] data;
    logic       side;
    logic       last;
  } fud_result_t;

  // One queue entry holds every result caused by one input beat.
  typedef struct packed {
    logic        two;
    fud_result_t r0;
    fud_result_t r1;
  } fud_entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } fud_hex_t;

  function automatic fud_hex_t hex_val(input logic [7:0] b);
    fud_hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nib = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.nib = 4'(b - 8'h41 + 8'd10);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.nib = 4'(b - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/fud_front.sv
// Front end: classifies each body byte, updates the decode state and
// packs the resulting one or two results into a queue entry. Uses fud_pkg.
module fud_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              body_end_i,
  output logic              push_o,
  output fud_pkg::fud_entry_t entry_o
);
  import fud_pkg::*;

  logic       value_side_q, value_side_d;
  fud_phase_e phase_q, phase_d;
  logic [3:0] high_nib_q, high_nib_d;
  logic       discard_q, discard_d;

  fud_hex_t    hx;
  fud_result_t r0, r1;
  logic [1:0]  n;
  logic        err;

  assign hx = hex_val(in_byte_i);

  always_comb begin
    value_side_d = value_side_q;
    phase_d      = phase_q;
    high_nib_d   = high_nib_q;
    discard_d    = discard_q;
    r0  = '{kind: KIND_DATA, data: 8'd0, side: 1'b0, last: 1'b0};
    r1  = r0;
    n   = 2'd0;
    err = 1'b0;
    if (discard_q) begin
      if (body_end_i) begin
        value_side_d = 1'b0;
        phase_d      = PHASE_NONE;
        high_nib_d   = 4'd0;
        discard_d    = 1'b0;
      end
    end else begin
      if (phase_q == PHASE_FIRST || phase_q == PHASE_SECND) begin
        if (!hx.ok) begin
          err = 1'b1;
        end else if (phase_q == PHASE_FIRST) begin
          high_nib_d = hx.nib;
          phase_d    = PHASE_SECND;
          err        = body_end_i;
        end else begin
          r0.data    = {high_nib_q, hx.nib};
          r0.side    = value_side_q;
          n          = 2'd1;
          phase_d    = PHASE_NONE;
          high_nib_d = 4'd0;
        end
      end else begin
        phase_d = PHASE_NONE;
        case (in_byte_i)
          CHAR_PLUS: begin
            r0.data = CHAR_SPACE;
            r0.side = value_side_q;
            n       = 2'd1;
          end
          CHAR_PERCENT: begin
            phase_d = PHASE_FIRST;
            err     = body_end_i;
          end
          CHAR_EQUALS: begin
            value_side_d = 1'b1;
          end
          CHAR_AMP: begin
            r0.kind      = KIND_CLOSE;
            n            = 2'd1;
            value_side_d = 1'b0;
          end
          default: begin
            r0.data = in_byte_i;
            r0.side = value_side_q;
            n       = 2'd1;
          end
        endcase
      end
      if (err) begin
        // drop any partial result, report once, then discard to end of body
        r0           = '{kind: KIND_ERROR, data: 8'd0, side: 1'b0, last: 1'b0};
        n            = 2'd1;
        value_side_d = 1'b0;
        phase_d      = PHASE_NONE;
        high_nib_d   = 4'd0;
        discard_d    = !body_end_i;
      end else if (body_end_i) begin
        if (n == 2'd0) begin
          r0.kind = KIND_CLOSE;
        end else begin
          r1.kind = KIND_CLOSE;
        end
        n            = n + 2'd1;
        value_side_d = 1'b0;
        phase_d      = PHASE_NONE;
        high_nib_d   = 4'd0;
        discard_d    = 1'b0;
      end
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_side_q <= 1'b0;
      phase_q      <= PHASE_NONE;
      high_nib_q   <= 4'd0;
      discard_q    <= 1'b0;
    end else if (accept_i) begin
      value_side_q <= value_side_d;
      phase_q      <= phase_d;
      high_nib_q   <= high_nib_d;
      discard_q    <= discard_d;
    end
  end

  assign push_o        = accept_i && (n != 2'd0);
  assign entry_o.two   = (n == 2'd2);
  assign entry_o.r0    = r0;
  assign entry_o.r1    = r1;

endmodule

>>> rtl/fud_queue.sv
// Small FIFO of result entries between front and back end.
// Uses fud_pkg for the entry type; depth comes from the top level.
module fud_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fud_pkg::fud_entry_t entry_i,
  input  logic                pop_i,
  output fud_pkg::fud_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);
  import fud_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  fud_entry_t      slots_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/fud_back.sv
// Back end: unpacks queue entries into single result beats held in an
// output register. Uses fud_pkg for the entry and result types.
module fud_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fud_pkg::fud_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output fud_pkg::fud_result_t out_o
);
  import fud_pkg::*;

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  fud_result_t res_q, res_d;
  fud_result_t second_q, second_d;
  logic        load;

  always_comb begin
    valid_d  = valid_q;
    pend_d   = pend_q;
    res_d    = res_q;
    second_d = second_q;
    pop_o    = 1'b0;
    load     = !valid_q || !out_stall_i;
    if (load) begin
      if (pend_q) begin
        res_d   = second_q;
        valid_d = 1'b1;
        pend_d  = 1'b0;
      end else if (!empty_i) begin
        pop_o    = 1'b1;
        res_d    = head_i.r0;
        second_d = head_i.r1;
        valid_d  = 1'b1;
        pend_d   = head_i.two;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    second_q <= second_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

>>> rtl/form_urlencoded_decoder.sv
// Top level of the streaming x-www-form-urlencoded percent decoder.
// Depends on fud_pkg, fud_front, fud_queue and fud_back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_byte_i, body_end_i
//  out     | output    | out_valid_o/out_stall_i | out_kind_o, out_byte_o,
//          |           |                         | in_value_part_o, last_of_run_o
//
// One input beat is taken every cycle while the result queue has room; the
// front end decodes it in that same cycle. The back end delivers one result
// beat per cycle while out_stall_i is low, so a byte that causes two results
// costs the output side two beats, and the queue (QueueDepth entries) absorbs
// that. Results pass through the queue and then the output register. Reset clears
// the decode state, the queue and the output register at once. in_stall_o rises
// only when the queue is full; out_stall_i holds the current result beat in place.
module form_urlencoded_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       body_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       in_value_part_o,
  output logic       last_of_run_o
);
  import fud_pkg::*;

  logic        accept;
  logic        push, pop, q_empty, q_full;
  fud_entry_t  entry, head;
  fud_result_t res;

  // take a byte whenever the queue can hold what it may produce
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  fud_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .body_end_i (body_end_i),
    .push_o     (push),
    .entry_o    (entry)
  );

  fud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign out_kind_o      = res.kind;
  assign out_byte_o      = res.data;
  assign in_value_part_o = res.side;
  assign last_of_run_o   = res.last;

  // an error report always ends its run
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_ERROR |-> last_of_run_o)
    else $error("error result not marked last");

  // non-data results carry a zero byte and key side
  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_DATA |-> out_byte_o == 8'd0 && !in_value_part_o)
    else $error("control result with payload");

  // a pop only happens when the queue has an entry to give
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // a full queue never takes a push
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full queue");

endmodule

>>> test/tb_form_urlencoded_decoder.sv
`timescale 1ns / 1ps
// Self-checking bench for form_urlencoded_decoder: directed table, then random form bodies.
// Depends on fud_pkg for the result kinds, escape phases and special characters.
module tb_form_urlencoded_decoder;
  import fud_pkg::*;

  // Stop the run after this many cycles in which no beat moves on either channel.
  localparam int unsigned QuietLimit = 2000;
  // Give the result queue this long to show any stray beat after the last expected one.
  localparam int unsigned DrainCycles = 16;
  // Random beats to send in each of the three idling phases.
  localparam int unsigned PhaseBeats = 283;
  localparam int unsigned DirectedRows = 26;

  // One row of the directed table. When typed is set, cnt and r0/r1 give the results
  // by hand; otherwise the decode model below works them out.
  typedef struct {
    logic [7:0]  b;
    logic        eob;
    logic        typed;
    int          cnt;
    fud_result_t r0;
    fud_result_t r1;
  } body_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       body_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       in_value_part_o;
  logic       last_of_run_o;

  // Decode state mirrored from the block.
  logic       on_value;
  fud_phase_e esc_phase;
  logic [3:0] hi_nib;
  logic       dropping;

  fud_result_t owed_results[$];  // results the block still owes, oldest first
  fud_result_t want;
  logic [7:0]  body_q[$];        // bytes of the random body about to be sent

  int unsigned gap_pct;          // chance in a hundred that the sender idles a cycle
  int unsigned stall_pct;        // chance in a hundred that the receiver stalls a cycle
  int unsigned beats_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  body_row_t directed_body[DirectedRows] = '{
    // Plain bytes after reset, including both byte extremes, all on the key side.
    '{8'h61, 1'b0, 1'b1, 1, '{KIND_DATA, 8'h61, 1'b0, 1'b1}, '0},
    '{8'h00, 1'b0, 1'b1, 1, '{KIND_DATA, 8'h00, 1'b0, 1'b1}, '0},
    '{8'hFF, 1'b0, 1'b1, 1, '{KIND_DATA, 8'hFF, 1'b0, 1'b1}, '0},
    '{CHAR_PLUS,    1'b0, 1'b0, 0, '0, '0},
    // Switch to the value side, then repeat the equals sign.
    '{CHAR_EQUALS,  1'b0, 1'b0, 0, '0, '0},
    '{CHAR_EQUALS,  1'b0, 1'b0, 0, '0, '0},
    // Escapes with digits, upper and lower case letters.
    '{CHAR_PERCENT, 1'b0, 1'b0, 0, '0, '0},
    '{8'h34, 1'b0, 1'b0, 0, '0, '0},
    '{8'h31, 1'b0, 1'b0, 0, '0, '0},
    '{CHAR_PERCENT, 1'b0, 1'b0, 0, '0, '0},
    '{8'h66, 1'b0, 1'b0, 0, '0, '0},
    '{8'h46, 1'b0, 1'b0, 0, '0, '0},
    '{CHAR_AMP, 1'b0, 1'b1, 1, '{KIND_CLOSE, 8'h00, 1'b0, 1'b1}, '0},
    // Bad digit in an escape, then bytes dropped up to the end of the body.
    '{CHAR_PERCENT, 1'b0, 1'b0, 0, '0, '0},
    '{8'h67, 1'b0, 1'b1, 1, '{KIND_ERROR, 8'h00, 1'b0, 1'b1}, '0},
    '{8'h78, 1'b0, 1'b0, 0, '0, '0},
    '{8'h79, 1'b1, 1'b0, 0, '0, '0},
    // Ampersand as the final byte closes two pairs.
    '{CHAR_AMP, 1'b1, 1'b1, 2, '{KIND_CLOSE, 8'h00, 1'b0, 1'b0},
      '{KIND_CLOSE, 8'h00, 1'b0, 1'b1}},
    // Escapes cut short by the end of the body, after the percent and after one digit.
    '{CHAR_PERCENT, 1'b1, 1'b1, 1, '{KIND_ERROR, 8'h00, 1'b0, 1'b1}, '0},
    '{CHAR_PERCENT, 1'b0, 1'b0, 0, '0, '0},
    '{8'h41, 1'b1, 1'b1, 1, '{KIND_ERROR, 8'h00, 1'b0, 1'b1}, '0},
    // Ordinary last byte: data, then the closing of the pair.
    '{8'h7A, 1'b1, 1'b0, 0, '0, '0},
    // Top byte value as a bad second digit, then a dropped end of body.
    '{CHAR_PERCENT, 1'b0, 1'b0, 0, '0, '0},
    '{8'h39, 1'b0, 1'b0, 0, '0, '0},
    '{8'hFF, 1'b0, 1'b1, 1, '{KIND_ERROR, 8'h00, 1'b0, 1'b1}, '0},
    '{8'h00, 1'b1, 1'b0, 0, '0, '0}
  };

  form_urlencoded_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .body_end_i     (body_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .in_value_part_o(in_value_part_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Decode one accepted byte and append the results it owes to owed_results.
  function automatic void percent_decode(input logic [7:0] b, input logic eob);
    fud_result_t run[$];
    logic        fault;
    logic        digit_ok;
    logic [3:0]  digit;
    fault    = 1'b0;
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (dropping) begin
      // Drop everything after an error; the end of the body starts afresh.
      if (eob) begin
        on_value  = 1'b0;
        esc_phase = PHASE_NONE;
        hi_nib    = 4'd0;
        dropping  = 1'b0;
      end
      return;
    end
    if (esc_phase == PHASE_FIRST || esc_phase == PHASE_SECND) begin
      if (b >= "0" && b <= "9") begin
        digit = 4'(b - "0");
      end else if (b >= "A" && b <= "F") begin
        digit = 4'(b - "A" + 8'd10);
      end else if (b >= "a" && b <= "f") begin
        digit = 4'(b - "a" + 8'd10);
      end else begin
        digit_ok = 1'b0;
      end
      if (!digit_ok) begin
        fault = 1'b1;
      end else if (esc_phase == PHASE_FIRST) begin
        hi_nib    = digit;
        esc_phase = PHASE_SECND;
        if (eob) fault = 1'b1;
      end else begin
        run.push_back(fud_result_t'{KIND_DATA, {hi_nib, digit}, on_value, 1'b0});
        esc_phase = PHASE_NONE;
        hi_nib    = 4'd0;
      end
    end else begin
      esc_phase = PHASE_NONE;
      case (b)
        CHAR_PLUS: begin
          run.push_back(fud_result_t'{KIND_DATA, CHAR_SPACE, on_value, 1'b0});
        end
        CHAR_PERCENT: begin
          esc_phase = PHASE_FIRST;
          if (eob) fault = 1'b1;
        end
        CHAR_EQUALS: begin
          on_value = 1'b1;
        end
        CHAR_AMP: begin
          run.push_back(fud_result_t'{KIND_CLOSE, 8'h00, 1'b0, 1'b0});
          on_value = 1'b0;
        end
        default: begin
          run.push_back(fud_result_t'{KIND_DATA, b, on_value, 1'b0});
        end
      endcase
    end
    if (fault) begin
      // An error replaces anything the byte would have produced.
      run.delete();
      run.push_back(fud_result_t'{KIND_ERROR, 8'h00, 1'b0, 1'b0});
    end else if (eob) begin
      run.push_back(fud_result_t'{KIND_CLOSE, 8'h00, 1'b0, 1'b0});
    end
    if (fault || eob) begin
      on_value  = 1'b0;
      esc_phase = PHASE_NONE;
      hi_nib    = 4'd0;
      dropping  = fault && !eob;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) owed_results.push_back(run[i]);
  endfunction

  // Present one beat and hold it until the block takes it. Idle first at random;
  // the choice never looks at in_stall_o.
  task automatic drive_beat(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    body_end_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Append n bytes of pair text: plain letters and digits, plus signs, escapes of
  // random bytes in random case, and now and then a raw byte of any value.
  function automatic void add_text(input int unsigned n);
    int unsigned pick;
    logic [3:0]  nib;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        body_q.push_back(($urandom_range(1) != 0) ? 8'h61 + 8'($urandom_range(25))
                                                   : 8'h30 + 8'($urandom_range(9)));
      end else if (pick < 70) begin
        body_q.push_back(CHAR_PLUS);
      end else if (pick < 92) begin
        body_q.push_back(CHAR_PERCENT);
        repeat (2) begin
          nib = 4'($urandom);
          body_q.push_back((nib < 4'd10) ? 8'h30 + 8'(nib)
                           : ((($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10));
        end
      end else begin
        body_q.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  // Build one random body. Most bodies are well-formed key=value pairs joined by
  // ampersands; the rest are noise rich in escapes cut short and bad digits.
  task automatic compose_body();
    int unsigned pairs;
    body_q.delete();
    if ($urandom_range(99) < 85) begin
      pairs = $urandom_range(1, 3);
      for (int p = 0; p < pairs; p++) begin
        if (p > 0) body_q.push_back(CHAR_AMP);
        add_text($urandom_range(0, 4));
        if ($urandom_range(9) != 0) begin
          body_q.push_back(CHAR_EQUALS);
          add_text($urandom_range(0, 5));
        end
      end
      if ($urandom_range(9) == 0) body_q.push_back(CHAR_AMP);
      if (body_q.size() == 0) add_text(1);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(7))
          0, 1:    body_q.push_back(CHAR_PERCENT);
          2:       body_q.push_back(8'h30 + 8'($urandom_range(9)));
          3:       body_q.push_back(8'h41 + 8'($urandom_range(5)));
          4:       body_q.push_back(CHAR_AMP);
          5:       body_q.push_back(CHAR_EQUALS);
          6:       body_q.push_back(CHAR_PLUS);
          default: body_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // Result side: check each accepted beat against the oldest owed result, then
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind=%0d byte=%h side=%b last=%b",
                 $time, out_kind_o, out_byte_o, in_value_part_o, last_of_run_o);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (out_kind_o !== want.kind || out_byte_o !== want.data ||
            in_value_part_o !== want.side || last_of_run_o !== want.last) begin
          $display("%0t: result mismatch, expected %0d/%h/%b/%b, actual %0d/%h/%b/%b",
                   $time, want.kind, want.data, want.side, want.last,
                   out_kind_o, out_byte_o, in_value_part_o, last_of_run_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    on_value     = 1'b0;
    esc_phase    = PHASE_NONE;
    hi_nib       = 4'd0;
    dropping     = 1'b0;
    beats_sent   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    gap_pct      = 19;
    stall_pct    = 65;

    // Hold reset, then release it once for the whole run.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table. Advance the model on every row so its state
    // stays in step; on typed rows, swap its results for the ones in the row.
    foreach (directed_body[i]) begin
      int unsigned owed_before;
      drive_beat(directed_body[i].b, directed_body[i].eob);
      owed_before = owed_results.size();
      percent_decode(directed_body[i].b, directed_body[i].eob);
      if (directed_body[i].typed) begin
        while (owed_results.size() > owed_before) void'(owed_results.pop_back());
        if (directed_body[i].cnt >= 1) owed_results.push_back(directed_body[i].r0);
        if (directed_body[i].cnt >= 2) owed_results.push_back(directed_body[i].r1);
      end
    end

    // Random bodies in three idling phases: sender light and receiver heavy,
    // then the reverse, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin gap_pct = 19; stall_pct = 65; end
        1: begin gap_pct = 65; stall_pct = 19; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      target = DirectedRows + (phase + 1) * PhaseBeats;
      while (beats_sent < target) begin
        compose_body();
        foreach (body_q[j]) begin
          drive_beat(body_q[j], j == body_q.size() - 1);
          percent_decode(body_q[j], j == body_q.size() - 1);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every owed result, then linger to catch any stray beat.
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
